@@ sv/hfa_pkg.sv @@
// Package for the hole-fit allocator: operation, mode, policy and status codes.
// No dependencies; hfa_front, hfa_back and the top unit import it.

package hfa_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] mode_t;
    typedef logic [1:0] policy_t;
    typedef logic [1:0] status_t;

    // Input mode codes as they arrive on the port.
    localparam mode_t MODE_CLEAR   = 2'd0;
    localparam mode_t MODE_APPEND  = 2'd1;
    localparam mode_t MODE_REQUEST = 2'd2;

    // Internal operation codes held in the queue.
    localparam op_t OP_CLEAR   = 2'd0;
    localparam op_t OP_APPEND  = 2'd1;
    localparam op_t OP_REQUEST = 2'd2;
    localparam op_t OP_NOP     = 2'd3;

    // Placement rules.
    localparam policy_t POL_FIRST = 2'd0;
    localparam policy_t POL_NEXT  = 2'd1;
    localparam policy_t POL_BEST  = 2'd2;
    localparam policy_t POL_WORST = 2'd3;

    // Result status codes.
    localparam status_t ST_DONE   = 2'd0;
    localparam status_t ST_NO_FIT = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

endpackage

@@ sv/hfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module hfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/hfa_front.sv @@
// Front end of the hole-fit allocator: accepts input items, turns the mode into
// an operation code, trims the size and holds items in a two-entry queue.
// Depends on hfa_pkg.

module hfa_front
    import hfa_pkg::*;
#(
    parameter int SIZE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic [15:0]          size,
    output logic                 q_valid,
    output op_t                  q_op,
    output logic [SIZE_BITS-1:0] q_size,
    input  logic                 q_pop
);

    logic [1:0]           cnt_reg, cnt_next;
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    op_t                  op_reg   [2];
    logic [SIZE_BITS-1:0] size_reg [2];
    logic                 push;
    logic                 pop;
    op_t                  op_in;
    logic [31:0]          size_wide;

    assign size_wide = 32'(size);

    always_comb
    begin
        case (mode)
            MODE_CLEAR:   op_in = OP_CLEAR;
            MODE_APPEND:  op_in = OP_APPEND;
            MODE_REQUEST: op_in = OP_REQUEST;
            default:      op_in = OP_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_op     = op_reg[rd_ptr_reg];
    assign q_size   = size_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]   <= op_in;
            size_reg[wr_ptr_reg] <= size_wide[SIZE_BITS-1:0];
        end
    end

endmodule

@@ sv/hfa_back.sv @@
// Back end of the hole-fit allocator: carries out queued operations, scans the
// hole table in RAM one entry per cycle and holds the result register.
// Depends on hfa_pkg; drives the ports of an hfa_ram instance.

module hfa_back
    import hfa_pkg::*;
#(
    parameter int MAX_HOLES = 16,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = $clog2(MAX_HOLES),
    parameter int CNT_W     = $clog2(MAX_HOLES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  policy_t              policy,
    input  logic                 q_valid,
    input  op_t                  q_op,
    input  logic [SIZE_BITS-1:0] q_size,
    output logic                 q_pop,
    output logic                 ram_we,
    output logic [IDX_W-1:0]     ram_waddr,
    output logic [SIZE_BITS-1:0] ram_wdata,
    output logic [IDX_W-1:0]     ram_raddr,
    input  logic [SIZE_BITS-1:0] ram_rdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 granted,
    output logic [3:0]           hole_index,
    output logic [15:0]          remaining,
    output status_t              status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     rover_reg, rover_next;
    logic [CNT_W-1:0]     issued_reg, issued_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic                 dv_reg, dv_next;
    logic [IDX_W-1:0]     didx_reg, didx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] val_reg, val_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 granted_reg, granted_next;
    logic [3:0]           index_reg, index_next;
    logic [15:0]          rem_reg, rem_next;
    status_t              status_reg, status_next;

    logic                 out_free;
    logic                 full;
    logic                 issue;
    logic                 fit;
    logic                 take;
    logic                 grant;
    logic [SIZE_BITS-1:0] new_val;
    logic [IDX_W-1:0]     scan_step;
    logic [IDX_W-1:0]     rover_start;
    logic [IDX_W-1:0]     pick_step;

    assign out_free = !out_valid_reg || out_ready;
    assign full     = (count_reg == CNT_W'(MAX_HOLES));
    assign issue    = (issued_reg != count_reg);
    assign fit      = (ram_rdata >= req_reg);
    assign new_val  = val_reg - req_reg;
    assign grant    = found_reg && ((policy != POL_WORST) || (val_reg >= req_reg));

    // Scan order wraps at the number of holes in use, not at the table size.
    assign scan_step   = (CNT_W'(scan_reg) + CNT_W'(1) < count_reg) ?
                         scan_reg + IDX_W'(1) : '0;
    assign pick_step   = (CNT_W'(pick_reg) + CNT_W'(1) < count_reg) ?
                         pick_reg + IDX_W'(1) : '0;
    assign rover_start = (policy == POL_NEXT && CNT_W'(rover_reg) < count_reg) ?
                         rover_reg : '0;

    always_comb
    begin
        case (policy)
            POL_FIRST, POL_NEXT: take = fit && !found_reg;
            POL_BEST:            take = fit && (!found_reg || ram_rdata < val_reg);
            default:             take = !found_reg || ram_rdata > val_reg;
        endcase
    end

    assign ram_raddr = scan_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rover_next     = rover_reg;
        issued_next    = issued_reg;
        scan_next      = scan_reg;
        dv_next        = 1'b0;
        didx_next      = scan_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        val_next       = val_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && !out_ready;
        granted_next   = granted_reg;
        index_next     = index_reg;
        rem_next       = rem_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = q_size;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    granted_next   = 1'b0;
                    index_next     = 4'd0;
                    rem_next       = 16'd0;
                    status_next    = ST_DONE;
                    case (q_op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            rover_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                index_next = 4'(count_reg[IDX_W-1:0]);
                                rem_next   = 16'(32'(q_size));
                            end
                        end
                        OP_REQUEST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NO_FIT;
                            end
                            else
                            begin
                                // The result is produced at the end of the scan.
                                out_valid_next = 1'b0;
                                req_next       = q_size;
                                issued_next    = '0;
                                scan_next      = rover_start;
                                found_next     = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    dv_next     = 1'b1;
                    issued_next = issued_reg + CNT_W'(1);
                    scan_next   = scan_step;
                end
                else
                begin
                    state_next = S_FINISH;
                end
                if (dv_reg && take)
                begin
                    found_next = 1'b1;
                    pick_next  = didx_reg;
                    val_next   = ram_rdata;
                end
            end
            S_FINISH:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (grant)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = pick_reg;
                    ram_wdata    = new_val;
                    granted_next = 1'b1;
                    index_next   = 4'(8'(pick_reg));
                    rem_next     = 16'(32'(new_val));
                    status_next  = ST_DONE;
                    if (policy == POL_NEXT)
                    begin
                        rover_next = pick_step;
                    end
                end
                else
                begin
                    granted_next = 1'b0;
                    index_next   = 4'd0;
                    rem_next     = 16'd0;
                    status_next  = ST_NO_FIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rover_reg     <= '0;
            issued_reg    <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rover_reg     <= rover_next;
            issued_reg    <= issued_next;
            dv_reg        <= dv_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        didx_reg    <= didx_next;
        pick_reg    <= pick_next;
        val_reg     <= val_next;
        req_reg     <= req_next;
        granted_reg <= granted_next;
        index_reg   <= index_next;
        rem_reg     <= rem_next;
        status_reg  <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign granted    = granted_reg;
    assign hole_index = index_reg;
    assign remaining  = rem_reg;
    assign status     = status_reg;

endmodule

@@ sv/hole_fit_allocator_unit.sv @@
// Hole-fit allocator. An accepted item passes through the two-entry queue before
// it reaches the result register. Clear, append and unused modes are carried out
// in the idle state; a request scans the hole RAM one entry per cycle and then
// sets the result in a finish state.
// Reset clears the hole count, the rover, the policy (first fit) and the queue;
// the hole RAM is not cleared and needs no pass after reset.

module hole_fit_allocator_unit
    import hfa_pkg::*;
#(
    parameter int MAX_HOLES = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        granted,
    output logic [3:0]  hole_index,
    output logic [15:0] remaining,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  policy
);

    localparam int IDX_W = $clog2(MAX_HOLES);

    policy_t              policy_reg;
    logic                 q_valid;
    op_t                  q_op;
    logic [SIZE_BITS-1:0] q_size;
    logic                 q_pop;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
        end
        else if (cfg_valid)
        begin
            policy_reg <= policy;
        end
    end

    hfa_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .size     (size),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_size   (q_size),
        .q_pop    (q_pop)
    );

    hfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_HOLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hfa_back #(
        .MAX_HOLES (MAX_HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .policy     (policy_reg),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_size     (q_size),
        .q_pop      (q_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .granted    (granted),
        .hole_index (hole_index),
        .remaining  (remaining),
        .status     (status)
    );

endmodule
